>>> rtl/stfl_pkg.sv
// ----------------------------------------------------------------------------
// stfl_pkg
// Shared types and constants for the sorted table floor lookup block.
// ----------------------------------------------------------------------------
package stfl_pkg;

   localparam int TABLE_DEPTH   = 1024;
   localparam int IDX_W         = $clog2(TABLE_DEPTH);
   localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);
   localparam int DATA_W        = 64;
   localparam int FOUND_INDEX_W = 10;

   typedef enum logic [1:0] {
      OP_APPEND    = 2'd0,
      OP_CLEAR     = 2'd1,
      OP_BY_TIME   = 2'd2,
      OP_BY_OFFSET = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHK_FIRST,
      S_CHK_LAST,
      S_STEP,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic accept;
      logic chk_first;
      logic chk_last;
      logic step;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic lookup_go;
      logic first_hit;
      logic last_hit;
      logic search_more;
   } stat_type;

endpackage

>>> rtl/stfl_ram.sv
// ----------------------------------------------------------------------------
// stfl_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module stfl_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/stfl_ctrl.sv
// ----------------------------------------------------------------------------
// stfl_ctrl
// Sequencer: accept, clamp checks, halving steps and result hand-off.
// ----------------------------------------------------------------------------
module stfl_ctrl
   import stfl_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = stat.lookup_go ? S_CHK_FIRST : S_FINISH;
            end
         end
         S_CHK_FIRST: begin
            cmd.chk_first = 1'b1;
            state_in      = stat.first_hit ? S_FINISH : S_CHK_LAST;
         end
         S_CHK_LAST: begin
            cmd.chk_last = 1'b1;
            if (!stat.last_hit && stat.search_more) begin
               state_in = S_STEP;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_STEP: begin
            cmd.step = 1'b1;
            state_in = stat.search_more ? S_STEP : S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/stfl_dp.sv
// ----------------------------------------------------------------------------
// stfl_dp
// Table storage, entry count, search bounds and result registers.
// ----------------------------------------------------------------------------
module stfl_dp
   import stfl_pkg::*;
(
   input  logic                            clock,
   input  logic                            reset,
   input  cmd_type                         cmd,
   output stat_type                        stat,
   input  logic [1:0]                      req_operation,
   input  logic signed [DATA_W-1:0]        req_search_key,
   input  logic signed [DATA_W-1:0]        req_new_time,
   input  logic signed [DATA_W-1:0]        req_new_offset,
   output logic signed [DATA_W-1:0]        rsp_found_time,
   output logic signed [DATA_W-1:0]        rsp_found_offset,
   output logic [FOUND_INDEX_W-1:0]        rsp_found_index,
   output logic [1:0]                      rsp_status
);

   op_type                   req_op;
   op_type                   op_ff;
   status_type               status_ff, status_in;
   logic signed [DATA_W-1:0] key_ff;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [IDX_W-1:0]         lo_ff, lo_in;
   logic [IDX_W-1:0]         hi_ff, hi_in;
   logic [IDX_W-1:0]         addr_ff, addr_in;
   logic [IDX_W-1:0]         last_idx;
   logic [IDX_W:0]           bound_sum;
   logic [IDX_W-1:0]         mid;
   logic [IDX_W-1:0]         adv_addr;
   logic                     full;
   logic                     wr_en;
   logic                     rd_en;
   logic [DATA_W-1:0]        time_rdata;
   logic [DATA_W-1:0]        off_rdata;
   logic signed [DATA_W-1:0] col_rd;
   logic                     key_lt_col;
   logic                     col_lt_key;

   logic signed [DATA_W-1:0]  found_time_ff, found_time_in;
   logic signed [DATA_W-1:0]  found_offset_ff, found_offset_in;
   logic [FOUND_INDEX_W-1:0]  found_index_ff, found_index_in;
   status_type                rsp_status_ff;

   assign req_op   = op_type'(req_operation);
   assign full     = (count_ff == CNT_W'(TABLE_DEPTH));
   assign last_idx = IDX_W'(count_ff - CNT_W'(1));
   assign wr_en    = cmd.accept && (req_op == OP_APPEND) && !full;
   assign rd_en    = cmd.accept || cmd.chk_first || cmd.chk_last || cmd.step;

   stfl_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_time_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (req_new_time),
      .rd_en   (rd_en),
      .rd_addr (addr_in),
      .rd_data (time_rdata)
   );

   stfl_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_offset_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (req_new_offset),
      .rd_en   (rd_en),
      .rd_addr (addr_in),
      .rd_data (off_rdata)
   );

   assign col_rd     = (op_ff == OP_BY_TIME) ? $signed(time_rdata) : $signed(off_rdata);
   assign key_lt_col = key_ff < col_rd;
   assign col_lt_key = col_rd < key_ff;

   // start the bounds at the whole table on the last-entry check, else narrow them around the probed entry
   always_comb begin
      if (cmd.chk_last) begin
         lo_in = '0;
         hi_in = last_idx;
      end else if (key_lt_col) begin
         lo_in = lo_ff;
         hi_in = addr_ff;
      end else begin
         lo_in = addr_ff;
         hi_in = hi_ff;
      end
   end

   assign bound_sum        = {1'b0, lo_in} + {1'b0, hi_in};
   assign mid              = bound_sum[IDX_W:1];
   assign stat.search_more = ({1'b0, lo_in} + (IDX_W+1)'(1)) < {1'b0, hi_in};
   assign adv_addr         = stat.search_more ? mid : lo_in;

   assign stat.lookup_go = (req_op inside {OP_BY_TIME, OP_BY_OFFSET}) && (count_ff != '0);
   assign stat.first_hit = !col_lt_key;
   assign stat.last_hit  = !key_lt_col;

   always_comb begin
      addr_in = addr_ff;
      if (cmd.accept) begin
         addr_in = '0;
      end else if (cmd.chk_first) begin
         addr_in = stat.first_hit ? '0 : last_idx;
      end else if (cmd.chk_last) begin
         addr_in = stat.last_hit ? last_idx : adv_addr;
      end else if (cmd.step) begin
         addr_in = adv_addr;
      end
   end

   always_comb begin
      count_in  = count_ff;
      status_in = ST_OK;
      case (req_op)
         OP_APPEND: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_CLEAR: begin
            count_in = '0;
         end
         OP_BY_TIME, OP_BY_OFFSET: begin
            if (count_ff == '0) begin
               status_in = ST_EMPTY;
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.accept) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff     <= req_op;
         key_ff    <= req_search_key;
         status_ff <= status_in;
      end
      if (cmd.chk_last || cmd.step) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
      addr_ff <= addr_in;
   end

   always_comb begin
      found_time_in   = '0;
      found_offset_in = '0;
      found_index_in  = '0;
      if (status_ff == ST_EMPTY) begin
         found_time_in   = -64'sd1;
         found_offset_in = -64'sd1;
      end else if ((status_ff == ST_OK) && (op_ff inside {OP_BY_TIME, OP_BY_OFFSET})) begin
         found_offset_in = $signed(off_rdata);
         found_index_in  = FOUND_INDEX_W'(addr_ff);
         if (op_ff == OP_BY_TIME) begin
            found_time_in = $signed(time_rdata);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         found_time_ff   <= found_time_in;
         found_offset_ff <= found_offset_in;
         found_index_ff  <= found_index_in;
         rsp_status_ff   <= status_ff;
      end
   end

   assign rsp_found_time   = found_time_ff;
   assign rsp_found_offset = found_offset_ff;
   assign rsp_found_index  = found_index_ff;
   assign rsp_status       = rsp_status_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_step_bounds: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (({1'b0, lo_ff} + (IDX_W+1)'(1)) < {1'b0, hi_ff}))
      else $error("halving step with collapsed bounds");

   a_probe_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.step || cmd.chk_first || cmd.chk_last) |-> ({1'b0, addr_ff} < count_ff))
      else $error("probe beyond filled entries");

   a_hit_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && (status_ff == ST_OK) && (op_ff == OP_BY_TIME || op_ff == OP_BY_OFFSET))
      |-> ({1'b0, addr_ff} < count_ff))
      else $error("selected index beyond filled entries");
`endif

endmodule

>>> rtl/sorted_table_floor_lookup.sv
// ----------------------------------------------------------------------------
// sorted_table_floor_lookup
// Append/clear table of (timestamp, offset) pairs with floor binary search.
//
// channel  ports  direction  contents
// request  req_*  in         operation, search key, pair to append
// result   rsp_*  out        found time, found offset, found index, status
//
// Append, clear and lookup on an empty table go from accept straight to the result hand-off.
// Lookup: checks against the first and last entries, then halving steps until the
// bounds meet, then the hand-off, serial because of the single read port of each table.
// One item is in work at a time; a result waits in the output register.
// Reset empties the table; table contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_table_floor_lookup
   import stfl_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_operation,
   input  logic signed [DATA_W-1:0] req_search_key,
   input  logic signed [DATA_W-1:0] req_new_time,
   input  logic signed [DATA_W-1:0] req_new_offset,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_found_time,
   output logic signed [DATA_W-1:0] rsp_found_offset,
   output logic [FOUND_INDEX_W-1:0] rsp_found_index,
   output logic [1:0]               rsp_status
);

   cmd_type  cmd;
   stat_type stat;

   stfl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   stfl_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_operation    (req_operation),
      .req_search_key   (req_search_key),
      .req_new_time     (req_new_time),
      .req_new_offset   (req_new_offset),
      .rsp_found_time   (rsp_found_time),
      .rsp_found_offset (rsp_found_offset),
      .rsp_found_index  (rsp_found_index),
      .rsp_status       (rsp_status)
   );

endmodule

>>> test/sorted_table_floor_lookup_tb.sv
// ----------------------------------------------------------------------------
// sorted_table_floor_lookup_tb
// Self-checking bench for the sorted table floor lookup block. A directed
// table covers the empty table, the extremes of both columns, clear and a
// small unsorted table. Random segments then build ascending tables of mixed
// size, with one filled to the limit, and look them up by time and by offset
// with some noise. Each result is checked against its directed row's answer
// or a behavioural predictor. Both handshakes see random gaps.
// ----------------------------------------------------------------------------
module sorted_table_floor_lookup_tb
   import stfl_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [DATA_W-1:0] word_type;

   typedef struct {
      op_type                   op;
      word_type                 found_time;
      word_type                 found_offset;
      logic [FOUND_INDEX_W-1:0] found_index;
      status_type               status;
   } table_answer_type;

   typedef struct {
      op_type           op;
      word_type         key;
      word_type         new_time;
      word_type         new_offset;
      bit               typed;
      table_answer_type want;
   } stim_row_type;

   localparam word_type    W_MIN    = 64'sh8000_0000_0000_0000;
   localparam word_type    W_MAX    = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam word_type    NONE     = -64'sd1;
   localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
   localparam int          ITEM_GOAL = 1450;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [1:0]               req_operation = OP_APPEND;
   logic signed [DATA_W-1:0] req_search_key = '0;
   logic signed [DATA_W-1:0] req_new_time = '0;
   logic signed [DATA_W-1:0] req_new_offset = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [DATA_W-1:0] rsp_found_time;
   logic signed [DATA_W-1:0] rsp_found_offset;
   logic [FOUND_INDEX_W-1:0] rsp_found_index;
   logic [1:0]               rsp_status;

   sorted_table_floor_lookup DUT (.*);

   word_type         time_col [TABLE_DEPTH];
   word_type         offset_col [TABLE_DEPTH];
   int unsigned      stored = 0;
   table_answer_type answers_due [$];
   table_answer_type unused_answer;

   int  errors = 0;
   int  items_sent = 0;
   int  results_seen = 0;
   int  appends_kept = 0;
   int  appends_refused = 0;
   int  clears_seen = 0;
   int  lookups_seen = 0;
   int  empty_lookups = 0;
   bit  sender_steady = 1'b0;
   bit  sink_steady = 1'b0;
   bit  table_filled = 1'b0;

   stim_row_type directed_rows [24] = '{
      '{OP_BY_TIME, 64'sd0, 64'sd0, 64'sd0, 1'b1,
        '{OP_BY_TIME, NONE, NONE, 10'd0, ST_EMPTY}},
      '{OP_BY_OFFSET, W_MAX, 64'sd0, 64'sd0, 1'b1,
        '{OP_BY_OFFSET, NONE, NONE, 10'd0, ST_EMPTY}},
      '{OP_APPEND, 64'sd0, W_MIN, W_MIN, 1'b1,
        '{OP_APPEND, 64'sd0, 64'sd0, 10'd0, ST_OK}},
      '{OP_APPEND, 64'sd0, -64'sd5, 64'sd100, 1'b1,
        '{OP_APPEND, 64'sd0, 64'sd0, 10'd0, ST_OK}},
      '{OP_APPEND, 64'sd0, 64'sd0, 64'sd200, 1'b1,
        '{OP_APPEND, 64'sd0, 64'sd0, 10'd0, ST_OK}},
      '{OP_APPEND, 64'sd0, 64'sd1000, 64'sd300, 1'b1,
        '{OP_APPEND, 64'sd0, 64'sd0, 10'd0, ST_OK}},
      '{OP_APPEND, 64'sd0, W_MAX, W_MAX, 1'b1,
        '{OP_APPEND, 64'sd0, 64'sd0, 10'd0, ST_OK}},
      '{OP_BY_TIME, W_MIN, 64'sd0, 64'sd0, 1'b1,
        '{OP_BY_TIME, W_MIN, W_MIN, 10'd0, ST_OK}},
      '{OP_BY_TIME, W_MAX, 64'sd0, 64'sd0, 1'b1,
        '{OP_BY_TIME, W_MAX, W_MAX, 10'd4, ST_OK}},
      '{OP_BY_TIME, -64'sd1, 64'sd0, 64'sd0, 1'b0, unused_answer},
      '{OP_BY_TIME, 64'sd0, 64'sd0, 64'sd0, 1'b0, unused_answer},
      '{OP_BY_TIME, 64'sd999, 64'sd0, 64'sd0, 1'b0, unused_answer},
      '{OP_BY_OFFSET, W_MIN, 64'sd0, 64'sd0, 1'b1,
        '{OP_BY_OFFSET, 64'sd0, W_MIN, 10'd0, ST_OK}},
      '{OP_BY_OFFSET, W_MAX, 64'sd0, 64'sd0, 1'b1,
        '{OP_BY_OFFSET, 64'sd0, W_MAX, 10'd4, ST_OK}},
      '{OP_BY_OFFSET, 64'sd250, 64'sd0, 64'sd0, 1'b0, unused_answer},
      '{OP_CLEAR, 64'sd0, 64'sd0, 64'sd0, 1'b1,
        '{OP_CLEAR, 64'sd0, 64'sd0, 10'd0, ST_OK}},
      '{OP_BY_OFFSET, 64'sd5, 64'sd0, 64'sd0, 1'b1,
        '{OP_BY_OFFSET, NONE, NONE, 10'd0, ST_EMPTY}},
      '{OP_APPEND, 64'sd0, 64'sd7, 64'sd7, 1'b0, unused_answer},
      '{OP_BY_TIME, 64'sd3, 64'sd0, 64'sd0, 1'b0, unused_answer},
      '{OP_BY_TIME, 64'sd9, 64'sd0, 64'sd0, 1'b0, unused_answer},
      '{OP_APPEND, 64'sd0, 64'sd2, 64'sd50, 1'b0, unused_answer},
      '{OP_BY_TIME, 64'sd5, 64'sd0, 64'sd0, 1'b0, unused_answer},
      '{OP_BY_OFFSET, 64'sd20, 64'sd0, 64'sd0, 1'b0, unused_answer},
      '{OP_CLEAR, 64'sd0, 64'sd0, 64'sd0, 1'b1,
        '{OP_CLEAR, 64'sd0, 64'sd0, 10'd0, ST_OK}}
   };

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("sorted_table_floor_lookup verification failed");
      $finish;
   end

   function automatic word_type rand_word();
      return {$urandom(), $urandom()};
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(20, 60);
   endfunction

   function automatic word_type column_at(bit by_time, int unsigned idx);
      return by_time ? time_col[idx] : offset_col[idx];
   endfunction

   function automatic int unsigned floor_search(bit by_time, word_type key);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      if (!(column_at(by_time, 0) < key)) return 0;
      if (!(key < column_at(by_time, stored - 1))) return stored - 1;
      lo = 0;
      hi = stored - 1;
      while (lo + 1 < hi) begin
         mid = (lo + hi) / 2;
         if (key < column_at(by_time, mid)) hi = mid;
         else lo = mid;
      end
      return lo;
   endfunction

   function automatic table_answer_type predict_answer(op_type op, word_type key,
                                                       word_type nt, word_type no);
      table_answer_type ans;
      int unsigned      idx;
      ans = '{op, 64'sd0, 64'sd0, '0, ST_OK};
      case (op)
         OP_APPEND: begin
            if (stored >= TABLE_DEPTH) begin
               ans.status = ST_FULL;
            end else begin
               time_col[stored] = nt;
               offset_col[stored] = no;
               stored++;
            end
         end
         OP_CLEAR: begin
            stored = 0;
         end
         default: begin
            if (stored == 0) begin
               ans.found_time = NONE;
               ans.found_offset = NONE;
               ans.status = ST_EMPTY;
            end else begin
               idx = floor_search(op == OP_BY_TIME, key);
               if (op == OP_BY_TIME) ans.found_time = time_col[idx];
               ans.found_offset = offset_col[idx];
               ans.found_index = FOUND_INDEX_W'(idx);
            end
         end
      endcase
      return ans;
   endfunction

   // biased start point: 0 is the most negative value, SIGN_BIT is zero
   function automatic logic [63:0] pick_base();
      case ($urandom_range(0, 3))
         0: return 64'($urandom_range(0, 1000));
         1: return rand_word();
         2: return SIGN_BIT - 64'($urandom_range(0, 5000));
         default: return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 2000));
      endcase
   endfunction

   function automatic logic [63:0] step_up(logic [63:0] lin);
      logic [63:0] inc;
      case ($urandom_range(0, 4))
         0: inc = '0;
         1: inc = {24'd0, 8'($urandom()), $urandom()};
         default: inc = 64'($urandom_range(1, 1000));
      endcase
      if (lin > 64'hFFFF_FFFF_FFFF_FFFF - inc) return 64'hFFFF_FFFF_FFFF_FFFF;
      return lin + inc;
   endfunction

   function automatic word_type pick_key(bit by_time);
      word_type v;
      if (stored == 0) return rand_word();
      v = column_at(by_time, $urandom_range(0, stored - 1));
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return v;
         4: return v + 64'sd1;
         5: return v - 64'sd1;
         6: return W_MIN;
         7: return W_MAX;
         default: return rand_word();
      endcase
   endfunction

   task automatic issue_item(op_type op, word_type key, word_type nt, word_type no,
                             bit typed, table_answer_type want);
      int               gap;
      table_answer_type ans;
      gap = (sender_steady || $urandom_range(0, 1)) ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_search_key <= key;
      req_new_time <= nt;
      req_new_offset <= no;
      do @(posedge clock); while (req_ready !== 1'b1);
      ans = predict_answer(op, key, nt, no);
      if (typed) begin
         want.op = op;
         ans = want;
      end
      answers_due.push_back(ans);
      items_sent++;
   endtask

   task automatic issue_noise();
      issue_item(op_type'($urandom_range(0, 3)), rand_word(), rand_word(),
                 rand_word(), 1'b0, unused_answer);
   endtask

   task automatic run_segment(int n_app, int n_look, bit wipe, bit noisy);
      logic [63:0] t_lin;
      logic [63:0] o_lin;
      bit          by_time;
      t_lin = pick_base();
      o_lin = pick_base();
      if (wipe) issue_item(OP_CLEAR, rand_word(), rand_word(), rand_word(),
                           1'b0, unused_answer);
      for (int i = 0; i < n_app; i++) begin
         if (noisy && $urandom_range(0, 24) == 0) issue_noise();
         t_lin = step_up(t_lin);
         o_lin = step_up(o_lin);
         issue_item(OP_APPEND, rand_word(), word_type'(t_lin ^ SIGN_BIT),
                    word_type'(o_lin ^ SIGN_BIT), 1'b0, unused_answer);
      end
      for (int i = 0; i < n_look; i++) begin
         if (noisy && $urandom_range(0, 11) == 0) issue_noise();
         by_time = $urandom_range(0, 1);
         issue_item(by_time ? OP_BY_TIME : OP_BY_OFFSET, pick_key(by_time),
                    rand_word(), rand_word(), 1'b0, unused_answer);
      end
   endtask

   task automatic check_answer();
      table_answer_type want;
      if (answers_due.size() == 0) begin
         errors++;
         $display("%0t: unexpected result: time %0d offset %0d index %0d status %0d",
                  $time, rsp_found_time, rsp_found_offset, rsp_found_index, rsp_status);
      end else begin
         want = answers_due.pop_front();
         results_seen++;
         if (rsp_found_time !== want.found_time) begin
            errors++;
            $display("%0t: found_time expected %0d got %0d",
                     $time, want.found_time, rsp_found_time);
         end
         if (rsp_found_offset !== want.found_offset) begin
            errors++;
            $display("%0t: found_offset expected %0d got %0d",
                     $time, want.found_offset, rsp_found_offset);
         end
         if (rsp_found_index !== want.found_index) begin
            errors++;
            $display("%0t: found_index expected %0d got %0d",
                     $time, want.found_index, rsp_found_index);
         end
         if (rsp_status !== want.status) begin
            errors++;
            $display("%0t: status expected %0d got %0d", $time, want.status, rsp_status);
         end
         case (want.op)
            OP_APPEND: begin
               if (want.status == ST_FULL) appends_refused++;
               else appends_kept++;
            end
            OP_CLEAR: clears_seen++;
            default: begin
               lookups_seen++;
               if (want.status == ST_EMPTY) empty_lookups++;
            end
         endcase
      end
   endtask

   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_ready) check_answer();
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!sink_steady && $urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
         if ($urandom_range(0, 299) == 0) sink_steady = !sink_steady;
      end
   end

   initial begin
      int n_app;
      int n_look;
      int r;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i]) begin
         issue_item(directed_rows[i].op, directed_rows[i].key, directed_rows[i].new_time,
                    directed_rows[i].new_offset, directed_rows[i].typed,
                    directed_rows[i].want);
      end
      while (items_sent < ITEM_GOAL) begin
         sender_steady = ($urandom_range(0, 5) == 0);
         r = $urandom_range(0, 99);
         n_app = (r < 5) ? 0 : (r < 80) ? $urandom_range(1, 12) : $urandom_range(13, 60);
         n_look = $urandom_range(4, 20);
         if (!table_filled && items_sent >= 380) begin
            run_segment(TABLE_DEPTH + 4, 30, 1'b1, 1'b0);
            table_filled = 1'b1;
         end else begin
            run_segment(n_app, n_look, $urandom_range(0, 4) != 0, 1'b1);
         end
      end
      req_valid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("Checked %0d results: %0d pairs stored, %0d appends refused on a full table,",
               results_seen, appends_kept, appends_refused);
      $display("%0d clears, %0d lookups of which %0d hit an empty table",
               clears_seen, lookups_seen, empty_lookups);
      if (errors == 0) begin
         $display("sorted_table_floor_lookup verification clean");
      end else begin
         $display("sorted_table_floor_lookup verification failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/stfl_pkg.sv
rtl/stfl_ram.sv
rtl/stfl_ctrl.sv
rtl/stfl_dp.sv
rtl/sorted_table_floor_lookup.sv
test/sorted_table_floor_lookup_tb.sv
